// ===== sv/backlight_pwm_sleep_controller_assert.svh =====
// Assertion macros shared by the backlight controller RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef BACKLIGHT_PWM_SLEEP_CONTROLLER_ASSERT_SVH
`define BACKLIGHT_PWM_SLEEP_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPSC_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("backlight controller check failed");

// Consequent must hold in the cycle after the antecedent.
`define BPSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("backlight controller check failed");

`endif

// ===== sv/bpsc_pkg.sv =====
// Shared types and constants of the backlight PWM and sleep controller.
// Used by the configuration registers, the event core and the top level.
`default_nettype none

package bpsc_pkg;

  // Number of PWM steps in one period (valid range 2 to 127).
  localparam int unsigned PwmSteps = 100;
  localparam logic [6:0]  PwmStepsW = 7'(PwmSteps);

  localparam logic [6:0]  FullPercent    = 7'd100;
  localparam logic [5:0]  TimeoutShort   = 6'd30;
  localparam logic [5:0]  TimeoutLong    = 6'd60;
  localparam logic [15:0] MsPerSec       = 16'd1000;
  localparam logic [15:0] CountMax       = 16'hFFFF;
  localparam logic [6:0]  LevelReset     = 7'd80;
  localparam logic [15:0] SaveDelayReset = 16'd1500;
  localparam logic [6:0]  MinBrightReset = 7'd25;

  // Event codes carried in the input tuser.
  typedef enum logic [2:0] {
    OP_PWM_TICK   = 3'd0,
    OP_MS_TICK    = 3'd1,
    OP_TOUCH      = 3'd2,
    OP_SET_BRIGHT = 3'd3,
    OP_SET_TMO    = 3'd4,
    OP_RESTORE    = 3'd5
  } op_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SAVE_DELAY = 1'b0,
    CFG_MIN_BRIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] save_delay_ms;
    logic [6:0]  min_brightness;
  } cfg_t;

  typedef struct packed {
    logic [5:0] timeout_now;
    logic [6:0] brightness_now;
    logic       save_now;
    logic       woke_from_sleep;
    logic       asleep;
    logic       backlight_on;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/bpsc_cfg_regs.sv =====
// Configuration registers: save delay and minimum brightness.
// Depends on bpsc_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module bpsc_cfg_regs
  import bpsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire logic [0:0]  wr_index_i,
  input  wire logic [15:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.save_delay_ms  <= SaveDelayReset;
      cfg_q.min_brightness <= MinBrightReset;
    end else if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CFG_SAVE_DELAY: cfg_q.save_delay_ms  <= wr_data_i;
        CFG_MIN_BRIGHT: cfg_q.min_brightness <= wr_data_i[6:0];
        default:        cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/bpsc_core.sv =====
// Event core: controller state and its combinational next-state update for one event.
// Depends on bpsc_pkg; assertions use the shared macro header.
`default_nettype none
`include "backlight_pwm_sleep_controller_assert.svh"

module bpsc_core
  import bpsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_en_i,
  input  wire logic [2:0]  op_i,
  input  wire logic [7:0]  bright_i,
  input  wire logic [15:0] tmo_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  logic [6:0]  level_q, level_d;
  logic [5:0]  limit_q, limit_d;
  logic        sleep_q, sleep_d;
  logic        phase_hi_q, phase_hi_d;
  logic [6:0]  step_q, step_d;
  logic [15:0] idle_q, idle_d;
  logic        dirty_q, dirty_d;
  logic [15:0] chg_q, chg_d;

  logic        woke, save;
  logic        pwm_active;
  logic [6:0]  phase_len;
  logic [7:0]  step_inc;
  logic [15:0] idle_inc, chg_inc, idle_thresh;
  logic [7:0]  min_ext, clamp_lo, clamp_v;
  logic        tmo_keep, tmo_ok, restore_ok;

  // Helpers for the PWM counter, the saturating counters and the clamps.
  assign pwm_active  = !sleep_q && (level_q != 7'd0) && (level_q < PwmStepsW);
  assign phase_len   = phase_hi_q ? level_q : (PwmStepsW - level_q);
  assign step_inc    = {1'b0, step_q} + 8'd1;
  assign idle_inc    = (idle_q == CountMax) ? CountMax : idle_q + 16'd1;
  assign chg_inc     = (chg_q == CountMax) ? CountMax : chg_q + 16'd1;
  assign idle_thresh = {10'd0, limit_q} * MsPerSec;
  assign min_ext     = {1'b0, cfg_i.min_brightness};
  assign clamp_lo    = (bright_i < min_ext) ? min_ext : bright_i;
  assign clamp_v     = (clamp_lo > {1'b0, FullPercent}) ? {1'b0, FullPercent} : clamp_lo;
  assign tmo_keep    = (tmo_i == {10'd0, TimeoutShort}) || (tmo_i == {10'd0, TimeoutLong});
  assign tmo_ok      = tmo_keep || (tmo_i == 16'd0);
  assign restore_ok  = (bright_i >= min_ext) && (bright_i <= {1'b0, FullPercent}) && tmo_ok;

  // Next state for the current event.
  always_comb begin
    level_d    = level_q;
    limit_d    = limit_q;
    sleep_d    = sleep_q;
    phase_hi_d = phase_hi_q;
    step_d     = step_q;
    idle_d     = idle_q;
    dirty_d    = dirty_q;
    chg_d      = chg_q;
    woke       = 1'b0;
    save       = 1'b0;
    unique case (op_i)
      OP_PWM_TICK: begin
        if (pwm_active) begin
          if (step_inc >= {1'b0, phase_len}) begin
            phase_hi_d = !phase_hi_q;
            step_d     = 7'd0;
          end else begin
            step_d = step_inc[6:0];
          end
        end
      end
      OP_MS_TICK: begin
        idle_d = idle_inc;
        chg_d  = chg_inc;
        if (dirty_q && (chg_inc >= cfg_i.save_delay_ms)) begin
          save    = 1'b1;
          dirty_d = 1'b0;
        end
        if (!sleep_q && (limit_q != 6'd0) && (idle_inc >= idle_thresh)) begin
          sleep_d    = 1'b1;
          phase_hi_d = 1'b1;
          step_d     = 7'd0;
        end
      end
      OP_TOUCH: begin
        woke   = sleep_q;
        idle_d = 16'd0;
        if (sleep_q) begin
          sleep_d    = 1'b0;
          phase_hi_d = 1'b1;
          step_d     = 7'd0;
        end
      end
      OP_SET_BRIGHT: begin
        level_d    = clamp_v[6:0];
        dirty_d    = 1'b1;
        chg_d      = 16'd0;
        phase_hi_d = 1'b1;
        step_d     = 7'd0;
      end
      OP_SET_TMO: begin
        limit_d = tmo_keep ? tmo_i[5:0] : 6'd0;
        idle_d  = 16'd0;
        dirty_d = 1'b1;
        chg_d   = 16'd0;
      end
      OP_RESTORE: begin
        if (restore_ok) begin
          level_d    = bright_i[6:0];
          limit_d    = tmo_i[5:0];
          phase_hi_d = 1'b1;
          step_d     = 7'd0;
        end
      end
      default: begin
        level_d = level_q;
      end
    endcase
  end

  // State registers advance only when an event is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= LevelReset;
      limit_q    <= 6'd0;
      sleep_q    <= 1'b0;
      phase_hi_q <= 1'b1;
      step_q     <= 7'd0;
      idle_q     <= 16'd0;
      dirty_q    <= 1'b0;
      chg_q      <= 16'd0;
    end else if (step_en_i) begin
      level_q    <= level_d;
      limit_q    <= limit_d;
      sleep_q    <= sleep_d;
      phase_hi_q <= phase_hi_d;
      step_q     <= step_d;
      idle_q     <= idle_d;
      dirty_q    <= dirty_d;
      chg_q      <= chg_d;
    end
  end

  // Result reflects the state after the event.
  always_comb begin
    res_o.woke_from_sleep = woke;
    res_o.save_now        = save;
    res_o.asleep          = sleep_d;
    res_o.brightness_now  = level_d;
    res_o.timeout_now     = limit_d;
    if (sleep_d) begin
      res_o.backlight_on = 1'b0;
    end else if (level_d >= PwmStepsW) begin
      res_o.backlight_on = 1'b1;
    end else if (level_d == 7'd0) begin
      res_o.backlight_on = 1'b0;
    end else begin
      res_o.backlight_on = phase_hi_d;
    end
  end

  `BPSC_ASSERT_SAME(a_lit_means_awake, clk_i, rst_ni, step_en_i && res_o.backlight_on, !res_o.asleep)
  `BPSC_ASSERT_SAME(a_wake_clears_sleep, clk_i, rst_ni, step_en_i && res_o.woke_from_sleep, !res_o.asleep)
  `BPSC_ASSERT_NEXT(a_save_clears_dirty, clk_i, rst_ni, step_en_i && res_o.save_now, !dirty_q)

endmodule

`default_nettype wire

// ===== sv/backlight_pwm_sleep_controller.sv =====
// Top level of the backlight PWM dimmer with idle sleep and delayed save.
// Depends on bpsc_pkg, bpsc_cfg_regs, bpsc_core and the assertion macro header.
//
//   Channel   Direction  Handshake               Payload
//   s_axis    in         tvalid / tready         tuser opcode, tdata brightness, timeout
//   m_axis    out        tvalid / tready         tdata result flags, brightness, timeout
//   cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each event passes from input transfer to result through an input register,
// then the state update into the result register.
// Sustained rate is one event per cycle while m_axis_tready stays high, limited by the single state update.
// While a result waits for m_axis_tready, the input register takes one more
// event and then holds s_axis_tready low until the result is taken.
// Reset clears the valid flags, the configuration and the core state to their defaults; no clearing pass is needed.
// Configuration writes are always ready and take effect on the next cycle.
`default_nettype none
`include "backlight_pwm_sleep_controller_assert.svh"

module backlight_pwm_sleep_controller
  import bpsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] brightness_value, [23:8] timeout_value
  input  wire logic [23:0] s_axis_tdata,
  // [2:0] opcode
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] backlight_on, [1] asleep, [2] woke_from_sleep, [3] save_now,
  // [10:4] brightness_now, [16:11] timeout_now, [23:17] zero
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic        in_valid_q, in_valid_d;
  logic [2:0]  in_op_q;
  logic [7:0]  in_bright_q;
  logic [15:0] in_tmo_q;
  logic        out_valid_q, out_valid_d;
  res_t        out_q;
  res_t        res;
  cfg_t        cfg;
  logic        advance;

  assign cfg_ready_o = 1'b1;

  bpsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Event moves from the input register to the result register.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  bpsc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .op_i      (in_op_q),
    .bright_i  (in_bright_q),
    .tmo_i     (in_tmo_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Valid flags of the two stages.
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load on a transfer in and on an advance.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q     <= s_axis_tuser;
      in_bright_q <= s_axis_tdata[7:0];
      in_tmo_q    <= s_axis_tdata[23:8];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

  `BPSC_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, m_axis_tvalid)

endmodule

`default_nettype wire
